@@ design/av_sync_sample_count_corrector_assert.svh @@
// assertion macros used by the checker of this block
`ifndef AV_SYNC_SAMPLE_COUNT_CORRECTOR_ASSERT_SVH
`define AV_SYNC_SAMPLE_COUNT_CORRECTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define AVSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define AVSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/avsc_pkg.sv @@
package avsc_pkg;

    // field widths
    localparam int SAMPLES_W = 16;
    localparam int DIFF_W    = 32;
    localparam int WANTED_W  = 17;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // register widths
    localparam int WEIGHT_W = 16;
    localparam int THRESH_W = 24;
    localparam int NOSYNC_W = 31;
    localparam int RATE_W   = 19;
    localparam int WARMUP_W = 8;
    localparam int PCT_W    = 7;

    // state widths
    localparam int SUM_W   = 48;
    localparam int COUNT_W = 8;

    localparam int FRAC_BITS_DEF = 16;

    // serial multiplier operand widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 19;

    // serial divide by a hundred
    localparam int DIV_N_W   = 24;
    localparam int DIV_CNT_W = 5;
    localparam int REM_W     = 7;
    localparam logic [REM_W:0] DIVISOR = 8'd100;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_WEIGHT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NOSYNC  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WARMUP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERCENT = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd52016;
    localparam logic [THRESH_W-1:0] THRESH_RST = 24'd3043;
    localparam logic [NOSYNC_W-1:0] NOSYNC_RST = 31'd655360;
    localparam logic [RATE_W-1:0]   RATE_RST   = 19'd48000;
    localparam logic [WARMUP_W-1:0] WARMUP_RST = 8'd20;
    localparam logic [PCT_W-1:0]    PCT_RST    = 7'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WEIGHT,
        ST_SUM,
        ST_KEEP,
        ST_TEST,
        ST_RATE,
        ST_LOW,
        ST_DIVLO,
        ST_DIVHI,
        ST_CLIP,
        ST_DONE
    } state_t;

endpackage

@@ design/av_sync_sample_count_corrector.sv @@
// when audio is master or the filter resets, a frame goes from check straight to done;
// otherwise through the multiplies and, for a correction, the divides and the clip
// one frame at a time, held by the one-bit-per-cycle multiplier
// (19 steps for each of five products) and the bit-serial divide by 100 (24 steps, twice)
// reset: synchronous active low; registers take their reset values, filter sum and
// measurement count clear at once, no clearing pass
module av_sync_sample_count_corrector #(
    parameter int FRAC_BITS = avsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_samples[15:0], clock_diff[47:16]
    input  logic [avsc_pkg::S_TDATA_W-1:0]      s_tdata,
    // diff_valid[0], audio_is_master[1]
    input  logic [avsc_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // wanted_samples[16:0], zero pad[23:17]
    output logic [avsc_pkg::M_TDATA_W-1:0]      m_tdata,
    // corrected[0]
    output logic [avsc_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [avsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [avsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [avsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SAMPLES_W   = avsc_pkg::SAMPLES_W;
    localparam int DIFF_W      = avsc_pkg::DIFF_W;
    localparam int WANTED_W    = avsc_pkg::WANTED_W;
    localparam int SUM_W       = avsc_pkg::SUM_W;
    localparam int MUL_A_W     = avsc_pkg::MUL_A_W;
    localparam int MUL_B_W     = avsc_pkg::MUL_B_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W + 1;
    localparam int RATE_PROD_W = DIFF_W - 1 + avsc_pkg::RATE_W;
    localparam int DELTA_W     = RATE_PROD_W - FRAC_BITS;
    localparam int WIDE_W      = DELTA_W + 2;
    localparam int DIV_N_W     = avsc_pkg::DIV_N_W;
    localparam int REM_W       = avsc_pkg::REM_W;
    localparam int DIV_CNT_W   = avsc_pkg::DIV_CNT_W;
    localparam int WEIGHT_W    = avsc_pkg::WEIGHT_W;
    localparam int PCT_W       = avsc_pkg::PCT_W;

    // configuration registers
    logic [avsc_pkg::WEIGHT_W-1:0] weight_reg;
    logic [avsc_pkg::THRESH_W-1:0] thresh_reg;
    logic [avsc_pkg::NOSYNC_W-1:0] nosync_reg;
    logic [avsc_pkg::RATE_W-1:0]   rate_reg;
    logic [avsc_pkg::WARMUP_W-1:0] warmup_reg;
    logic [PCT_W-1:0]              pct_reg;

    avsc_pkg::state_t state_reg, state_next;

    // captured request
    logic [SAMPLES_W-1:0]     samples_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                     valid_reg;
    logic                     master_reg;

    // filter state
    logic signed [SUM_W-1:0]       diff_sum_reg, diff_sum_next;
    logic [avsc_pkg::COUNT_W-1:0]  count_reg, count_next;

    logic [DELTA_W-1:0]  delta_reg, delta_next;
    logic [WANTED_W-1:0] lo_reg, lo_next;
    logic [WANTED_W-1:0] hi_reg, hi_next;
    logic [WANTED_W-1:0] res_wanted_reg, res_wanted_next;
    logic                res_corr_reg, res_corr_next;

    // divider
    logic [DIV_N_W-1:0]   num_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [WANTED_W-1:0]  quot_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 div_load;
    logic [DIV_N_W-1:0]   div_load_val;
    logic                 div_run;
    logic                 div_last;
    logic [REM_W:0]       div_trial;
    logic                 div_ge;
    logic [REM_W-1:0]     rem_step;
    logic [WANTED_W-1:0]  quot_final;

    // output register
    logic                m_valid_reg;
    logic [WANTED_W-1:0] m_wanted_reg;
    logic                m_corr_reg;
    logic                out_load;

    // multiplier
    logic                       mul_start;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic                       mul_busy;
    logic signed [PROD_W-1:0]   mul_prod;

    // datapath
    logic [DIFF_W-1:0]          abs_diff;
    logic                       too_big;
    logic signed [SUM_W-1:0]    w_term;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]           abs_avg;
    logic                       pass;
    logic [WEIGHT_W:0]          keep;
    logic [PCT_W-1:0]           pct_eff;
    logic [PCT_W-1:0]           lo_mult;
    logic [PCT_W:0]             hi_mult;
    logic signed [WIDE_W-1:0]   samp_w;
    logic signed [WIDE_W-1:0]   delta_w;
    logic signed [WIDE_W-1:0]   wide;
    logic signed [WIDE_W-1:0]   lo_w;
    logic signed [WIDE_W-1:0]   hi_w;
    logic [WANTED_W-1:0]        clipped;

    logic cfg_wr;

    avsc_serial_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= avsc_pkg::WEIGHT_RST;
            thresh_reg <= avsc_pkg::THRESH_RST;
            nosync_reg <= avsc_pkg::NOSYNC_RST;
            rate_reg   <= avsc_pkg::RATE_RST;
            warmup_reg <= avsc_pkg::WARMUP_RST;
            pct_reg    <= avsc_pkg::PCT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[avsc_pkg::REG_IDX_W+1:2])
                avsc_pkg::REG_WEIGHT:  weight_reg <= pwdata[avsc_pkg::WEIGHT_W-1:0];
                avsc_pkg::REG_THRESH:  thresh_reg <= pwdata[avsc_pkg::THRESH_W-1:0];
                avsc_pkg::REG_NOSYNC:  nosync_reg <= pwdata[avsc_pkg::NOSYNC_W-1:0];
                avsc_pkg::REG_RATE:    rate_reg   <= pwdata[avsc_pkg::RATE_W-1:0];
                avsc_pkg::REG_WARMUP:  warmup_reg <= pwdata[avsc_pkg::WARMUP_W-1:0];
                avsc_pkg::REG_PERCENT: pct_reg    <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[avsc_pkg::REG_IDX_W+1:2])
            avsc_pkg::REG_WEIGHT:  prdata = 32'(weight_reg);
            avsc_pkg::REG_THRESH:  prdata = 32'(thresh_reg);
            avsc_pkg::REG_NOSYNC:  prdata = 32'(nosync_reg);
            avsc_pkg::REG_RATE:    prdata = 32'(rate_reg);
            avsc_pkg::REG_WARMUP:  prdata = 32'(warmup_reg);
            avsc_pkg::REG_PERCENT: prdata = 32'(pct_reg);
            default:               prdata = '0;
        endcase
    end

    // arithmetic around the shared multiplier
    assign abs_diff = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign too_big  = abs_diff >= {1'b0, nosync_reg};

    assign w_term   = mul_prod[WEIGHT_W +: SUM_W];
    assign sum_wide = (SUM_W+1)'(diff_reg) + (SUM_W+1)'(w_term);

    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? avsc_pkg::SUM_MIN : avsc_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // product holds sum times keep once the keep multiply is done
    assign abs_avg = w_term[SUM_W-1] ? SUM_W'(-w_term) : SUM_W'(w_term);
    assign pass    = abs_avg >= SUM_W'(thresh_reg);

    assign keep    = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, weight_reg};
    assign pct_eff = (pct_reg > avsc_pkg::PCT_MAX) ? avsc_pkg::PCT_MAX : pct_reg;
    assign lo_mult = avsc_pkg::PCT_MAX - pct_eff;
    assign hi_mult = {1'b0, avsc_pkg::PCT_MAX} + {1'b0, pct_eff};

    assign samp_w  = $signed({{(WIDE_W-SAMPLES_W){1'b0}}, samples_reg});
    assign delta_w = $signed({2'b00, delta_reg});
    assign wide    = diff_reg[DIFF_W-1] ? samp_w - delta_w : samp_w + delta_w;
    assign lo_w    = $signed({{(WIDE_W-WANTED_W){1'b0}}, lo_reg});
    assign hi_w    = $signed({{(WIDE_W-WANTED_W){1'b0}}, hi_reg});

    always_comb begin
        if (wide < lo_w) begin
            clipped = lo_reg;
        end else if (wide > hi_w) begin
            clipped = hi_reg;
        end else begin
            clipped = wide[WANTED_W-1:0];
        end
    end

    // restoring divide by a hundred, one quotient bit a cycle
    assign div_trial  = {rem_reg, num_reg[DIV_N_W-1]};
    assign div_ge     = div_trial >= avsc_pkg::DIVISOR;
    assign rem_step   = div_ge ? REM_W'(div_trial - avsc_pkg::DIVISOR) : div_trial[REM_W-1:0];
    assign div_last   = div_cnt_reg == DIV_CNT_W'(DIV_N_W - 1);
    assign quot_final = {quot_reg[WANTED_W-2:0], div_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (div_load) begin
            div_cnt_reg <= '0;
        end else if (div_run) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_load) begin
            num_reg <= div_load_val;
            rem_reg <= '0;
        end else if (div_run) begin
            num_reg  <= {num_reg[DIV_N_W-2:0], 1'b0};
            rem_reg  <= rem_step;
            quot_reg <= quot_final;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            avsc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = avsc_pkg::ST_CHECK;
            end
            avsc_pkg::ST_CHECK: begin
                if (master_reg || !valid_reg || too_big) begin
                    state_next = avsc_pkg::ST_DONE;
                end else begin
                    state_next = avsc_pkg::ST_WEIGHT;
                end
            end
            avsc_pkg::ST_WEIGHT: begin
                if (!mul_busy) state_next = avsc_pkg::ST_SUM;
            end
            avsc_pkg::ST_SUM: begin
                if (count_reg < warmup_reg) begin
                    state_next = avsc_pkg::ST_DONE;
                end else begin
                    state_next = avsc_pkg::ST_KEEP;
                end
            end
            avsc_pkg::ST_KEEP: begin
                if (!mul_busy) state_next = avsc_pkg::ST_TEST;
            end
            avsc_pkg::ST_TEST: begin
                state_next = pass ? avsc_pkg::ST_RATE : avsc_pkg::ST_DONE;
            end
            avsc_pkg::ST_RATE: begin
                if (!mul_busy) state_next = avsc_pkg::ST_LOW;
            end
            avsc_pkg::ST_LOW: begin
                if (!mul_busy) state_next = avsc_pkg::ST_DIVLO;
            end
            avsc_pkg::ST_DIVLO: begin
                if (div_last) state_next = avsc_pkg::ST_DIVHI;
            end
            avsc_pkg::ST_DIVHI: begin
                if (div_last) state_next = avsc_pkg::ST_CLIP;
            end
            avsc_pkg::ST_CLIP: begin
                state_next = avsc_pkg::ST_DONE;
            end
            avsc_pkg::ST_DONE: begin
                if (out_load) state_next = avsc_pkg::ST_IDLE;
            end
            default: state_next = avsc_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        mul_start       = 1'b0;
        mul_a           = diff_sum_reg;
        mul_b           = MUL_B_W'(weight_reg);
        div_load        = 1'b0;
        div_load_val    = mul_prod[DIV_N_W-1:0];
        div_run         = 1'b0;
        diff_sum_next   = diff_sum_reg;
        count_next      = count_reg;
        delta_next      = delta_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_wanted_next = res_wanted_reg;
        res_corr_next   = res_corr_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            avsc_pkg::ST_IDLE: ;
            avsc_pkg::ST_CHECK: begin
                res_wanted_next = WANTED_W'(samples_reg);
                res_corr_next   = 1'b0;
                if (!master_reg) begin
                    if (!valid_reg || too_big) begin
                        diff_sum_next = '0;
                        count_next    = '0;
                    end else begin
                        mul_start = 1'b1;
                    end
                end
            end
            avsc_pkg::ST_WEIGHT: ;
            avsc_pkg::ST_SUM: begin
                diff_sum_next = sum_sat;
                if (count_reg < warmup_reg) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = sum_sat;
                    mul_b     = MUL_B_W'(keep);
                end
            end
            avsc_pkg::ST_KEEP: ;
            avsc_pkg::ST_TEST: begin
                if (pass) begin
                    mul_start = 1'b1;
                    mul_a     = $signed(MUL_A_W'(abs_diff));
                    mul_b     = rate_reg;
                end
            end
            avsc_pkg::ST_RATE: begin
                if (!mul_busy) begin
                    delta_next = mul_prod[FRAC_BITS +: DELTA_W];
                    mul_start  = 1'b1;
                    mul_a      = $signed(MUL_A_W'(samples_reg));
                    mul_b      = MUL_B_W'(lo_mult);
                end
            end
            avsc_pkg::ST_LOW: begin
                if (!mul_busy) begin
                    div_load  = 1'b1;
                    // upper bound product runs while the lower bound divides
                    mul_start = 1'b1;
                    mul_a     = $signed(MUL_A_W'(samples_reg));
                    mul_b     = MUL_B_W'(hi_mult);
                end
            end
            avsc_pkg::ST_DIVLO: begin
                div_run = 1'b1;
                if (div_last) begin
                    lo_next  = quot_final;
                    div_load = 1'b1;
                end
            end
            avsc_pkg::ST_DIVHI: begin
                div_run = 1'b1;
                if (div_last) hi_next = quot_final;
            end
            avsc_pkg::ST_CLIP: begin
                res_wanted_next = clipped;
                res_corr_next   = 1'b1;
            end
            avsc_pkg::ST_DONE: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= avsc_pkg::ST_IDLE;
            diff_sum_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            diff_sum_reg <= diff_sum_next;
            count_reg    <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            samples_reg <= s_tdata[SAMPLES_W-1:0];
            diff_reg    <= $signed(s_tdata[SAMPLES_W +: DIFF_W]);
            valid_reg   <= s_tuser[0];
            master_reg  <= s_tuser[1];
        end
        delta_reg      <= delta_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_wanted_reg <= res_wanted_next;
        res_corr_reg   <= res_corr_next;
        if (out_load) begin
            m_wanted_reg <= res_wanted_reg;
            m_corr_reg   <= res_corr_reg;
        end
    end

    assign s_tready = state_reg == avsc_pkg::ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(avsc_pkg::M_TDATA_W-WANTED_W){1'b0}}, m_wanted_reg};
    assign m_tuser  = m_corr_reg;

endmodule

@@ design/avsc_serial_mul.sv @@
module avsc_serial_mul #(
    parameter int A_W = avsc_pkg::MUL_A_W,
    parameter int B_W = avsc_pkg::MUL_B_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [A_W-1:0]  a,
    input  logic        [B_W-1:0]  b,
    output logic                   busy,
    output logic signed [A_W+B_W:0] product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic signed [A_W-1:0] a_reg;
    logic [A_W+B_W:0]      p_reg;
    logic [A_W+B_W:0]      p_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic [A_W:0]          hi;
    logic [A_W:0]          acc;

    // upper half accumulates, multiplier bits leave at the bottom
    assign hi  = p_reg[A_W+B_W:B_W];
    assign acc = p_reg[0] ? hi + {a_reg[A_W-1], a_reg} : hi;
    assign p_next = {acc[A_W], acc, p_reg[B_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(B_W - 1)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{(A_W+1){1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= p_next;
        end
    end

    assign busy    = busy_reg;
    assign product = $signed(p_reg);

endmodule

@@ design/avsc_checker.sv @@
`include "av_sync_sample_count_corrector_assert.svh"

module avsc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [avsc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [avsc_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           pready
);

    // a stalled result holds
    `AVSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one frame at a time: a request closes the input until its result is formed
    `AVSC_ASSERT_NEXT(a_one_frame, s_tvalid && s_tready, !s_tready, "input open right after a request")

    // sample count never reaches the pad bits
    `AVSC_ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[23:17] == 7'd0, "result pad bits set")

    `AVSC_ASSERT_SAME(a_pready, 1'b1, pready, "configuration port stalled")

endmodule

bind av_sync_sample_count_corrector avsc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avsc_pkg::*;

    // addresses past the register list, writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint DIFF_SPAN = 64'sd2147483648;

    typedef struct packed {
        logic [WANTED_W-1:0] wanted;
        logic                corrected;
    } wanted_count_t;

    class wanted_count_tracker;
        logic [WEIGHT_W-1:0] weight;
        logic [THRESH_W-1:0] thresh;
        logic [NOSYNC_W-1:0] nosync;
        logic [RATE_W-1:0]   rate;
        logic [WARMUP_W-1:0] warmup;
        logic [PCT_W-1:0]    pct;
        longint              diff_sum;
        int unsigned         measure_cnt;
        wanted_count_t       pending_counts[$];
        int                  errors;

        function new();
            weight      = WEIGHT_RST;
            thresh      = THRESH_RST;
            nosync      = NOSYNC_RST;
            rate        = RATE_RST;
            warmup      = WARMUP_RST;
            pct         = PCT_RST;
            diff_sum    = 0;
            measure_cnt = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] v);
            case (idx)
                REG_WEIGHT:  weight = v[WEIGHT_W-1:0];
                REG_THRESH:  thresh = v[THRESH_W-1:0];
                REG_NOSYNC:  nosync = v[NOSYNC_W-1:0];
                REG_RATE:    rate   = v[RATE_W-1:0];
                REG_WARMUP:  warmup = v[WARMUP_W-1:0];
                REG_PERCENT: pct    = v[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
            logic [APB_DATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_WEIGHT:  v[WEIGHT_W-1:0] = weight;
                REG_THRESH:  v[THRESH_W-1:0] = thresh;
                REG_NOSYNC:  v[NOSYNC_W-1:0] = nosync;
                REG_RATE:    v[RATE_W-1:0]   = rate;
                REG_WARMUP:  v[WARMUP_W-1:0] = warmup;
                REG_PERCENT: v[PCT_W-1:0]    = pct;
                default: ;
            endcase
            return v;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_frame(logic [SAMPLES_W-1:0] samples, logic signed [DIFF_W-1:0] diff,
                                 logic valid, logic master);
            longint        d;
            longint        prod;
            longint        keep;
            longint        avg;
            longint        delta;
            longint        lo;
            longint        hi;
            longint        wanted;
            longint        pct_cap;
            wanted_count_t r;
            d      = longint'(diff);
            wanted = longint'(samples);
            r.corrected = 1'b0;
            if (!master) begin
                if (valid && magnitude(d) < longint'(nosync)) begin
                    prod = longint'(weight) * diff_sum;
                    diff_sum = d + (prod >>> WEIGHT_W);
                    if (diff_sum > longint'(SUM_MAX))
                        diff_sum = longint'(SUM_MAX);
                    else if (diff_sum < longint'(SUM_MIN))
                        diff_sum = longint'(SUM_MIN);
                    if (measure_cnt < warmup) begin
                        measure_cnt = (measure_cnt + 1) & 8'hff;
                    end else begin
                        keep = (64'sd1 <<< WEIGHT_W) - longint'(weight);
                        avg  = (diff_sum * keep) >>> WEIGHT_W;
                        if (magnitude(avg) >= longint'(thresh)) begin
                            // magnitude first so the shift truncates toward zero
                            delta   = (magnitude(d) * longint'(rate)) >>> FRAC_BITS_DEF;
                            pct_cap = (pct > PCT_MAX) ? longint'(PCT_MAX) : longint'(pct);
                            lo      = longint'(samples) * (100 - pct_cap) / 100;
                            hi      = longint'(samples) * (100 + pct_cap) / 100;
                            if (d < 0)
                                delta = -delta;
                            wanted = longint'(samples) + delta;
                            if (wanted < lo)
                                wanted = lo;
                            else if (wanted > hi)
                                wanted = hi;
                            r.corrected = 1'b1;
                        end
                    end
                end else begin
                    diff_sum    = 0;
                    measure_cnt = 0;
                end
            end
            r.wanted = wanted[WANTED_W-1:0];
            pending_counts.push_back(r);
        endfunction

        function void check_result(logic [WANTED_W-1:0] wanted, logic corrected);
            wanted_count_t r;
            if (pending_counts.size() == 0) begin
                $error("result with no frame outstanding: wanted_samples %0d corrected %0d",
                       wanted, corrected);
                errors++;
                return;
            end
            r = pending_counts.pop_front();
            if (wanted !== r.wanted) begin
                $error("wanted_samples: expected %0d, actual %0d", r.wanted, wanted);
                errors++;
            end
            if (corrected !== r.corrected) begin
                $error("corrected: expected %0d, actual %0d", r.corrected, corrected);
                errors++;
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wanted_count_tracker sb = new();
    bit                  idle_on = 1'b1;
    int                  ready_stall = 0;

    av_sync_sample_count_corrector DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 0;
        else if (sel < 85)
            return $urandom_range(3, 1);
        else if (sel < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[WANTED_W-1:0], m_tuser[0]);
    end

    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (ready_stall > 0) begin
                m_tready <= 1'b0;
                ready_stall--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(3) == 0)
                    ready_stall = rand_gap();
            end
        end
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        for (int i = REG_WEIGHT; i <= REG_PERCENT; i++) begin
            @(negedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {i[REG_IDX_W-1:0], 2'b00};
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            rd = prdata;
            if (rd !== sb.reg_value(i[REG_IDX_W-1:0])) begin
                $error("register %0d: expected %0h, actual %0h", i,
                       sb.reg_value(i[REG_IDX_W-1:0]), rd);
                sb.errors++;
            end
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic send_frame(input logic [SAMPLES_W-1:0] samples,
                              input logic signed [DIFF_W-1:0] diff,
                              input logic valid, input logic master);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {diff, samples};
        s_tuser  <= {master, valid};
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(samples, diff, valid, master);
        if ($urandom_range(49) == 0)
            idle_on = !idle_on;
        gap = idle_on ? rand_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [SAMPLES_W-1:0] rand_samples();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return SAMPLES_W'($urandom_range(65535));
    endfunction

    task automatic random_frames(input int n, input int bias);
        int                       sel;
        int unsigned              top;
        int unsigned              mag;
        longint                   big;
        bit                       neg;
        logic signed [DIFF_W-1:0] diff;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                send_frame(rand_samples(), $urandom, 1'($urandom_range(1)), 1'b1);
            end else if (sel < 12) begin
                send_frame(rand_samples(), $urandom, 1'b0, 1'b0);
            end else if (sel < 16) begin
                // at or beyond the no-sync limit
                big = longint'(sb.nosync) + longint'($urandom) % (DIFF_SPAN - sb.nosync + 1);
                if (big >= DIFF_SPAN)
                    diff = 32'h8000_0000;
                else if ($urandom_range(1))
                    diff = DIFF_W'(-big);
                else
                    diff = DIFF_W'(big);
                send_frame(rand_samples(), diff, 1'b1, 1'b0);
            end else begin
                top = (sb.nosync == 0) ? 0 : sb.nosync - 1;
                case ($urandom_range(2))
                    0: mag = $urandom_range((top < 4095) ? top : 4095);
                    1: mag = $urandom_range((top < 200000) ? top : 200000);
                    default: mag = $urandom_range(top);
                endcase
                if (bias != 0 && $urandom_range(4) != 0)
                    neg = (bias < 0);
                else
                    neg = 1'($urandom_range(1));
                diff = neg ? DIFF_W'(-$signed({1'b0, mag})) : DIFF_W'($signed({1'b0, mag}));
                send_frame(rand_samples(), diff, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic run_phase(input logic [WEIGHT_W-1:0] w, input logic [THRESH_W-1:0] t,
                             input logic [NOSYNC_W-1:0] ns, input logic [RATE_W-1:0] r,
                             input logic [WARMUP_W-1:0] wu, input logic [PCT_W-1:0] p,
                             input int n, input int bias);
        drain();
        apb_write(REG_WEIGHT, APB_DATA_W'(w));
        apb_write(REG_THRESH, APB_DATA_W'(t));
        apb_write(REG_NOSYNC, APB_DATA_W'(ns));
        apb_write(REG_RATE, APB_DATA_W'(r));
        apb_write(REG_WARMUP, APB_DATA_W'(wu));
        apb_write(REG_PERCENT, APB_DATA_W'(p));
        check_regs();
        random_frames(n, bias);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values, then the special cases under them
        check_regs();
        send_frame('0, 0, 1'b1, 1'b1);
        send_frame('1, 32'sh7fff_ffff, 1'b1, 1'b1);
        send_frame('1, 32'sh8000_0000, 1'b0, 1'b0);
        send_frame(16'd1000, 655360, 1'b1, 1'b0);
        send_frame(16'd1000, -655360, 1'b1, 1'b0);
        repeat (20) send_frame(rand_samples(), 655359, 1'b1, 1'b0);
        // past warm-up: upper clip, small unclipped step, lower clip, truncation to zero
        send_frame('1, 655359, 1'b1, 1'b0);
        send_frame(16'd48000, 100, 1'b1, 1'b0);
        send_frame(16'd30000, -655359, 1'b1, 1'b0);
        send_frame(16'd30000, -655359, 1'b1, 1'b0);
        send_frame('0, -1, 1'b1, 1'b0);

        run_phase('0, '0, 31'h7fff_ffff, 19'd384000, '0, 7'd100, 120, 1);
        run_phase('1, '1, '0, 19'd1, 8'd255, '0, 40, 0);
        run_phase(WEIGHT_W'($urandom_range(65535)), 24'd2000, 31'd1 << 20, '0, 8'd3,
                  7'd127, 120, -1);

        drain();
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        check_regs();

        run_phase(16'd52016, 24'd1000, 31'd1 << 21, 19'd44100, 8'd5, 7'd101, 130, 0);
        run_phase('1, '0, 31'h7fff_ffff, 19'd384000, 8'd1, 7'd50, 130, -1);
        repeat (2)
            run_phase(WEIGHT_W'($urandom_range(65535)), THRESH_W'($urandom_range(8000)),
                      31'd1 << $urandom_range(24, 16), RATE_W'($urandom_range(384000, 1)),
                      WARMUP_W'($urandom_range(8)), PCT_W'($urandom_range(127)), 130, 0);

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("av_sync_sample_count_corrector regression: pass");
        end else begin
            $display("av_sync_sample_count_corrector regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("av_sync_sample_count_corrector regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/avsc_pkg.sv
design/avsc_serial_mul.sv
design/av_sync_sample_count_corrector.sv
design/avsc_checker.sv
tb/sv/tb.sv
